// ----- hw/rtl/wwr_pkg.sv -----
// ----------------------------------------------------------------------------
// wwr_pkg
// Shared types, constants and helpers of the whole-word replace stream core.
// ----------------------------------------------------------------------------
package wwr_pkg;

  // Longest word the pattern and the replacement can hold, in bytes
  localparam int unsigned MAX_WORD = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned WORD_W   = 8 * MAX_WORD;

  // Word separator
  localparam logic [7:0] SEP_CHAR = 8'd32;

  // Configuration register indexes (register i sits at byte address 8*i)
  localparam logic [1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [WORD_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]  pattern_length;
    logic [WORD_W-1:0] replacement_bytes;
    logic [LEN_W-1:0]  replacement_length;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // capture the incoming byte and plan its output
    logic emit_word;  // move the next word byte into the output register
    logic emit_byte;  // move the trailing byte into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;  // output register can take a byte this cycle
    logic plan_word;  // the incoming byte releases a word
    logic plan_byte;  // the incoming byte releases a trailing byte
    logic held_byte;  // the captured request still owes a trailing byte
    logic cnt_one;    // one word byte left to send
  } sts_t;

  // Clamp a length register to 1..MAX_WORD
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_WORD)) begin
      r = LEN_W'(MAX_WORD);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/whole_word_replace_stream_core.sv -----
// After a request is accepted, its first result byte enters the output register as soon
// as that register is free; later bytes follow one per cycle while out_tready allows.
// A new request is taken only after the previous one has sent all its result bytes (0 to 9)
// to the single output register, fed one byte per free cycle by the shifter.
// Reset (rst_n low, synchronous): match state and handshakes clear, registers return
// to pattern 0 / length 1 and replacement 0 / length 1.
// ----------------------------------------------------------------------------
// whole_word_replace_stream_core
// Byte-stream whole-word find and replace with APB configuration.
// ----------------------------------------------------------------------------
module whole_word_replace_stream_core
  import wwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast,
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  wwr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  wwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wwr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ----- hw/rtl/wwr_cfg.sv -----
// ----------------------------------------------------------------------------
// wwr_cfg
// APB register file holding the pattern and replacement words and lengths.
// ----------------------------------------------------------------------------
module wwr_cfg
  import wwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  logic [WORD_W-1:0] pattern_r;
  logic [LEN_W-1:0]  plen_r;
  logic [WORD_W-1:0] repl_r;
  logic [LEN_W-1:0]  rlen_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:3];

  // Write the addressed register at the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= LEN_W'(1);
      repl_r    <= '0;
      rlen_r    <= LEN_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_BYTES:      pattern_r <= cfg_pwdata;
        REG_PATTERN_LENGTH:     plen_r    <= cfg_pwdata[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  repl_r    <= cfg_pwdata;
        REG_REPLACEMENT_LENGTH: rlen_r    <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_PATTERN_BYTES:      cfg_prdata = pattern_r;
      REG_PATTERN_LENGTH:     cfg_prdata = {60'd0, plen_r};
      REG_REPLACEMENT_BYTES:  cfg_prdata = repl_r;
      REG_REPLACEMENT_LENGTH: cfg_prdata = {60'd0, rlen_r};
      default:                cfg_prdata = '0;
    endcase
  end

  assign cfg.pattern_bytes      = pattern_r;
  assign cfg.pattern_length     = plen_r;
  assign cfg.replacement_bytes  = repl_r;
  assign cfg.replacement_length = rlen_r;

endmodule

// ----- hw/rtl/wwr_dp.sv -----
// ----------------------------------------------------------------------------
// wwr_dp
// Datapath: match state, output plan, word shifter and output register.
// ----------------------------------------------------------------------------
module wwr_dp
  import wwr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic [LEN_W-1:0]  mc_r, mc_nxt;
  logic              mm_r, mm_nxt;
  logic [WORD_W-1:0] word_r;
  logic [LEN_W-1:0]  cnt_r;
  logic [7:0]        byte_r;
  logic              has_byte_r;
  logic              last_r;
  logic              oval_r;
  logic [7:0]        ochar_r;
  logic              olast_r;

  logic [LEN_W-1:0]  plen, rlen, mc_inc;
  logic [7:0]        pat_byte;
  logic              is_sep, hit;
  logic [WORD_W-1:0] plan_word;
  logic [LEN_W-1:0]  plan_len;
  logic              plan_byte;

  assign plen     = eff_len(cfg.pattern_length);
  assign rlen     = eff_len(cfg.replacement_length);
  assign mc_inc   = mc_r + LEN_W'(1);
  assign pat_byte = cfg.pattern_bytes[{mc_r[2:0], 3'b000} +: 8];
  assign is_sep   = (in_char == SEP_CHAR);
  assign hit      = !mm_r && (mc_r < plen) && (in_char == pat_byte);

  // Plan the output of one request: an optional word, then an optional byte
  always_comb begin
    plan_word = cfg.pattern_bytes;
    plan_len  = '0;
    plan_byte = 1'b0;
    mc_nxt    = mc_r;
    mm_nxt    = mm_r;
    if (is_sep) begin
      plan_byte = 1'b1;
      if (!mm_r) begin
        if (mc_r == plen) begin
          plan_word = cfg.replacement_bytes;
          plan_len  = rlen;
        end else begin
          plan_len  = mc_r;
        end
      end
      mc_nxt = '0;
      mm_nxt = 1'b0;
    end else if (mm_r) begin
      plan_byte = 1'b1;
    end else if (hit) begin
      mc_nxt = mc_inc;
      if (in_last) begin
        if (mc_inc == plen) begin
          plan_word = cfg.replacement_bytes;
          plan_len  = rlen;
        end else begin
          plan_len  = mc_inc;
        end
      end
    end else begin
      plan_len  = mc_r;
      plan_byte = 1'b1;
      mm_nxt    = 1'b1;
    end
    if (in_last) begin
      mc_nxt = '0;
      mm_nxt = 1'b0;
    end
  end

  // Hold match state across requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r <= '0;
      mm_r <= 1'b0;
    end else if (cmd.accept) begin
      mc_r <= mc_nxt;
      mm_r <= mm_nxt;
    end
  end

  // Capture the plan, then shift the word out one byte at a time
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r     <= plan_word;
      cnt_r      <= plan_len;
      byte_r     <= in_char;
      has_byte_r <= plan_byte;
      last_r     <= in_last;
    end else if (cmd.emit_word) begin
      word_r <= {8'd0, word_r[WORD_W-1:8]};
      cnt_r  <= cnt_r - LEN_W'(1);
    end
  end

  // Output register: load on emit, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (cmd.emit_word || cmd.emit_byte) begin
      oval_r <= 1'b1;
    end else if (out_ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      ochar_r <= word_r[7:0];
      olast_r <= last_r && (cnt_r == LEN_W'(1)) && !has_byte_r;
    end else if (cmd.emit_byte) begin
      ochar_r <= byte_r;
      olast_r <= last_r;
    end
  end

  assign out_valid = oval_r;
  assign out_char  = ochar_r;
  assign out_last  = olast_r;

  assign sts.slot_free = !oval_r || out_ready;
  assign sts.plan_word = (plan_len != '0);
  assign sts.plan_byte = plan_byte;
  assign sts.held_byte = has_byte_r;
  assign sts.cnt_one   = (cnt_r == LEN_W'(1));

endmodule

// ----- hw/rtl/wwr_ctrl.sv -----
// ----------------------------------------------------------------------------
// wwr_ctrl
// Controller: takes a request, then sequences its word and trailing byte.
// ----------------------------------------------------------------------------
module wwr_ctrl
  import wwr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WORD = 2'd1;
  localparam logic [1:0] S_BYTE = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready      = (state_r == S_IDLE);
  assign cmd.accept    = in_valid && in_ready;
  assign cmd.emit_word = (state_r == S_WORD) && sts.slot_free;
  assign cmd.emit_byte = (state_r == S_BYTE) && sts.slot_free;

  // Advance through word bytes, then the trailing byte
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          if (sts.plan_word) begin
            state_nxt = S_WORD;
          end else if (sts.plan_byte) begin
            state_nxt = S_BYTE;
          end
        end
      end
      S_WORD: begin
        if (cmd.emit_word && sts.cnt_one) begin
          state_nxt = sts.held_byte ? S_BYTE : S_IDLE;
        end
      end
      S_BYTE: begin
        if (cmd.emit_byte) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- dv/whole_word_replace_stream_checker.sv -----
// ----------------------------------------------------------------------------
// whole_word_replace_stream_checker
// Passive checker for the whole-word replace stream core. It snoops register
// writes on the configuration port, checks register reads against them, predicts
// the rewritten bytes released by each accepted input request and compares
// every accepted output request against the oldest predicted byte.
// ----------------------------------------------------------------------------
module whole_word_replace_stream_checker
  import wwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,
  // Result stream
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] out_char
  input  logic        out_tlast,
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  input  logic [63:0] cfg_prdata,
  input  logic        cfg_pready,
  // Status to the testbench top
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_byte_t;

  // Shadow registers
  logic [63:0] pat_word;
  logic [3:0]  pat_len_reg;
  logic [63:0] rep_word;
  logic [3:0]  rep_len_reg;

  // Match state of the current word
  logic [3:0]  match_len;
  logic        word_failed;

  out_byte_t   rewritten_q[$];
  out_byte_t   want;
  logic [63:0] want_rd;
  int          errors;

  // Clamp a length register to 1..MAX_WORD
  function automatic int unsigned usable_len(input logic [3:0] v);
    if (v == 4'd0) begin
      return 1;
    end
    if (v > MAX_WORD) begin
      return MAX_WORD;
    end
    return v;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    rewritten_q.push_back('{ch: c, last: 1'b0});
  endfunction

  // Release the pattern bytes matched so far
  function automatic void push_prefix();
    int unsigned k;
    for (k = 0; k < match_len; k++) begin
      push_char(pat_word[8*k +: 8]);
    end
  endfunction

  // End of word: replacement on a full match, else the pending prefix
  function automatic void close_word();
    int unsigned k;
    if (!word_failed) begin
      if (match_len == usable_len(pat_len_reg)) begin
        for (k = 0; k < usable_len(rep_len_reg); k++) begin
          push_char(rep_word[8*k +: 8]);
        end
      end else begin
        push_prefix();
      end
    end
    match_len   = 4'd0;
    word_failed = 1'b0;
  endfunction

  // Predict the bytes one input request releases
  function automatic void rewrite_byte(input logic [7:0] ch, input logic last);
    int unsigned start_n;
    out_byte_t   tail;
    start_n = rewritten_q.size();
    if (ch == SEP_CHAR) begin
      close_word();
      push_char(ch);
    end else begin
      if (word_failed) begin
        push_char(ch);
      end else if (match_len < usable_len(pat_len_reg) && ch == pat_word[8*match_len +: 8]) begin
        match_len = match_len + 4'd1;
      end else begin
        push_prefix();
        push_char(ch);
        word_failed = 1'b1;
      end
      if (last) begin
        close_word();
      end
    end
    // Sentence end: clear state and flag the final released byte
    if (last) begin
      match_len   = 4'd0;
      word_failed = 1'b0;
      if (rewritten_q.size() > start_n) begin
        tail      = rewritten_q.pop_back();
        tail.last = 1'b1;
        rewritten_q.push_back(tail);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pat_word    = '0;
      pat_len_reg = 4'd1;
      rep_word    = '0;
      rep_len_reg = 4'd1;
      match_len   = 4'd0;
      word_failed = 1'b0;
      rewritten_q.delete();
      errors      = 0;
    end else begin
      // Compare an output request with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (rewritten_q.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected output char %02h last %0d with nothing pending",
                     out_tdata, out_tlast);
          end
          errors++;
        end else begin
          want = rewritten_q.pop_front();
          if (want.ch !== out_tdata || want.last !== out_tlast) begin
            if (errors < 10) begin
              $display("output mismatch: expected char %02h last %0d, got char %02h last %0d",
                       want.ch, want.last, out_tdata, out_tlast);
            end
            errors++;
          end
        end
      end
      // Compare a register read with the shadow copy
      if (cfg_psel && cfg_penable && !cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_PATTERN_BYTES:      want_rd = pat_word;
          REG_PATTERN_LENGTH:     want_rd = {60'd0, pat_len_reg};
          REG_REPLACEMENT_BYTES:  want_rd = rep_word;
          REG_REPLACEMENT_LENGTH: want_rd = {60'd0, rep_len_reg};
          default:                want_rd = '0;
        endcase
        if (cfg_prdata !== want_rd) begin
          if (errors < 10) begin
            $display("register read mismatch at %02h: expected %016h, got %016h",
                     cfg_paddr, want_rd, cfg_prdata);
          end
          errors++;
        end
      end
      // Predict on an input request with the registers as they stood before this edge
      if (in_tvalid && in_tready) begin
        rewrite_byte(in_tdata, in_tlast);
      end
      // Track register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:3])
          REG_PATTERN_BYTES:      pat_word    = cfg_pwdata;
          REG_PATTERN_LENGTH:     pat_len_reg = cfg_pwdata[3:0];
          REG_REPLACEMENT_BYTES:  rep_word    = cfg_pwdata;
          REG_REPLACEMENT_LENGTH: rep_len_reg = cfg_pwdata[3:0];
          default: ;
        endcase
      end
    end
    pending_count  <= rewritten_q.size();
    mismatch_count <= errors;
  end

endmodule

// ----- dv/tb_whole_word_replace_stream_core.sv -----
// ----------------------------------------------------------------------------
// tb_whole_word_replace_stream_core
// Stimulus and verdict for the whole-word replace stream core. A short
// directed sentence set covers matches, prefixes, long words, empty words,
// byte zero, sentence ends and a register change in mid-word; random phases
// then stream sentences built mostly from the pattern under several register
// settings and idle/stall mixes. The checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb_whole_word_replace_stream_core
  import wwr_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 430;
  localparam int PHASES       = 9;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'd0;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = 5'd0;
  logic [63:0] cfg_pwdata  = 64'd0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  int          mismatch_count;
  int          pending_count;
  int          cycle_count    = 0;
  int          send_gap_pct   = 32;
  int          recv_stall_pct = 77;

  // Pattern as last written, used to shape random words
  logic [63:0] pat_word = 64'd0;
  int          pat_eff  = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  whole_word_replace_stream_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  whole_word_replace_stream_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Stall the result side at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("whole_word_replace_stream_core regression: fail");
      $finish;
    end
  end

  // Offer one byte, idling first at random, and hold it until accepted
  task automatic send_item(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text(input string text, input bit end_sentence);
    int i;
    for (i = 0; i < text.len(); i++) begin
      send_item(text[i], end_sentence && (i == text.len() - 1));
    end
  endtask

  // Drop valid and wait until every predicted byte has come out
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access until pready
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // One APB read: setup cycle, then access until pready
  task automatic read_reg(input logic [1:0] idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 3'b000};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic configure(input logic [63:0] pw, input logic [3:0] pl,
                           input logic [63:0] rw, input logic [3:0] rl);
    write_reg(REG_PATTERN_BYTES, pw);
    write_reg(REG_PATTERN_LENGTH, {60'd0, pl});
    write_reg(REG_REPLACEMENT_BYTES, rw);
    write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rl});
    read_reg(REG_PATTERN_BYTES);
    read_reg(REG_PATTERN_LENGTH);
    read_reg(REG_REPLACEMENT_BYTES);
    read_reg(REG_REPLACEMENT_LENGTH);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    pat_word = pw;
    pat_eff  = (pl == 4'd0) ? 1 : (pl > MAX_WORD) ? MAX_WORD : pl;
  endtask

  // Stream random sentences, mostly words built from the pattern
  task automatic run_random_phase(input int count);
    logic [8:0] chunk[$];
    logic [7:0] word[$];
    logic [8:0] item;
    int         sent;
    int         kind;
    int         len;
    int         k;
    int         pos;
    int         sep;
    sent = 0;
    while (sent < count) begin
      chunk.delete();
      word.delete();
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: begin
          for (k = 0; k < pat_eff; k++) word.push_back(pat_word[8*k +: 8]);
        end
        4: begin
          // proper prefix, possibly empty
          len = $urandom_range(pat_eff - 1);
          for (k = 0; k < len; k++) word.push_back(pat_word[8*k +: 8]);
        end
        5: begin
          // pattern with one corrupted byte
          for (k = 0; k < pat_eff; k++) word.push_back(pat_word[8*k +: 8]);
          pos = $urandom_range(pat_eff - 1);
          word[pos] = word[pos] ^ 8'($urandom_range(1, 255));
        end
        6: begin
          // pattern plus a tail: too long to match
          for (k = 0; k < pat_eff; k++) word.push_back(pat_word[8*k +: 8]);
          len = $urandom_range(1, 3);
          for (k = 0; k < len; k++) word.push_back(8'($urandom));
        end
        7: begin
          len = $urandom_range(1, 10);
          for (k = 0; k < len; k++) word.push_back(8'($urandom));
        end
        8: begin
          // bytes of the pattern in random order
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++) begin
            pos = $urandom_range(pat_eff - 1);
            word.push_back(pat_word[8*pos +: 8]);
          end
        end
        default: word.push_back(8'($urandom));
      endcase
      for (k = 0; k < word.size(); k++) chunk.push_back({1'b0, word[k]});
      // Separator or sentence end
      sep = $urandom_range(7);
      if (sep == 0 && chunk.size() > 0) begin
        chunk[chunk.size() - 1] = {1'b1, chunk[chunk.size() - 1][7:0]};
      end else if (sep <= 1) begin
        chunk.push_back({1'b1, SEP_CHAR});
      end else if (sep == 2) begin
        chunk.push_back({1'b0, SEP_CHAR});
        chunk.push_back({1'b0, SEP_CHAR});
      end else begin
        chunk.push_back({1'b0, SEP_CHAR});
      end
      while (chunk.size() > 0 && sent < count) begin
        item = chunk.pop_front();
        send_item(item[7:0], item[8]);
        sent++;
      end
    end
  endtask

  initial begin
    logic [63:0] pw;
    logic [63:0] rw;
    logic [3:0]  pl;
    logic [3:0]  rl;
    int          p;
    int          k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: byte zero matches the zero pattern
    send_item(8'h00, 1'b0);
    send_item(SEP_CHAR, 1'b0);
    settle();

    // Directed sentences on pattern "ab" with an all-ones 8-byte replacement
    configure(64'h6261, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
    send_text("ab ", 1'b0);
    send_text("a ", 1'b0);
    send_text(" ", 1'b0);
    send_text("abc ", 1'b0);
    send_text("ax ", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(SEP_CHAR, 1'b0);
    send_text("ab", 1'b1);
    send_text(" ", 1'b1);
    send_item(8'hFF, 1'b1);
    // Shorten the pattern while a word is half matched
    send_text("a", 1'b0);
    settle();
    configure(64'h61, 4'd1, 64'h5A, 4'd1);
    send_text(" ", 1'b0);
    settle();

    // Random phases: receiver-heavy idling, sender-heavy idling, then none
    for (p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_gap_pct   = 32;
        recv_stall_pct = 77;
      end else if (p < 6) begin
        send_gap_pct   = 77;
        recv_stall_pct = 32;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      pw = {$urandom, $urandom};
      rw = {$urandom, $urandom};
      pl = 4'($urandom_range(1, 8));
      rl = 4'($urandom_range(1, 8));
      case (p)
        0: begin pl = 4'd8;  rl = 4'd8; end
        1: begin pl = 4'd1;  rl = 4'd1; end
        2: begin pl = 4'd0;  rl = 4'd15; end
        3: begin pl = 4'd15; rl = 4'd0; pw = '1; end
        4: begin pw = '0; rw = '0; end
        5: begin pl = 4'd9;  rl = 4'd8; end
        8: begin pl = 4'd8;  rl = 4'd8; rw = '1; end
        default: ;
      endcase
      // keep separators out of the pattern so whole words can match
      for (k = 0; k < 8; k++) begin
        if (pw[8*k +: 8] == SEP_CHAR) begin
          pw[8*k +: 8] = 8'h2D;
        end
      end
      configure(pw, pl, rw, rl);
      run_random_phase(RANDOM_ITEMS / PHASES);
      settle();
    end

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("whole_word_replace_stream_core regression: pass");
    end else begin
      $display("whole_word_replace_stream_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- whole_word_replace_stream_core.f -----
hw/rtl/wwr_pkg.sv
hw/rtl/wwr_cfg.sv
hw/rtl/wwr_dp.sv
hw/rtl/wwr_ctrl.sv
hw/rtl/whole_word_replace_stream_core.sv
dv/whole_word_replace_stream_checker.sv
dv/tb_whole_word_replace_stream_core.sv
